@@ rtl/core/planar_velocity_slew_limiter_macros.svh @@
// ---------------------------------------------------------------------------
// planar velocity slew limiter assertion macros
// shared property shapes, clocked on clk with rst_n low as the disable
// ---------------------------------------------------------------------------
`ifndef PLANAR_VELOCITY_SLEW_LIMITER_MACROS_SVH
`define PLANAR_VELOCITY_SLEW_LIMITER_MACROS_SVH

// same-cycle implication
`define PVSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PVSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pvsl_pkg.sv @@
// ---------------------------------------------------------------------------
// pvsl_pkg
// types, codes and widths shared by the slew limiter modules
// ---------------------------------------------------------------------------
package pvsl_pkg;

  localparam int unsigned VelW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OpW    = 34;   // difference of two velocities
  localparam int unsigned ProdW  = 68;
  localparam int unsigned RadW   = 66;
  localparam int unsigned RootW  = 33;
  localparam int unsigned DvdW   = 64;
  localparam int unsigned QuotW  = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LIN_SPEED_LIMIT = 3'd0,
    REG_LIN_ACCEL_STEP  = 3'd1,
    REG_LIN_DECEL_STEP  = 3'd2,
    REG_YAW_SPEED_LIMIT = 3'd3,
    REG_YAW_ACCEL_STEP  = 3'd4,
    REG_YAW_DECEL_STEP  = 3'd5,
    REG_TIMEOUT_TICKS   = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    MUL_SQ_A,
    MUL_SQ_B,
    MUL_DOT_A,
    MUL_DOT_B,
    MUL_LIM_A,
    MUL_LIM_B
  } mul_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_YAW,
    S_SQA, S_SQB, S_SQRT, S_SQRTW, S_CMP,
    S_LIMA, S_DIVA, S_DIVAW, S_LIMB, S_DIVB, S_DIVBW,
    S_DOTA, S_DOTB, S_ACC, S_STEP,
    S_REVA, S_REVB, S_REVC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic     load_cmd;
    logic     load_tick;
    logic     yaw_upd;
    logic     set_phase;
    logic     phase;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sqrt_start;
    logic     div_start;
    logic     wr_a;
    logic     wr_b;
    logic     set_accel;
    logic     zero_v;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic spd_en;
    logic over;
    logic step_en;
    logic accel;
    logic neg;
    logic phase;
    logic sqrt_done;
    logic div_done;
  } sts_t;

endpackage

@@ rtl/core/planar_velocity_slew_limiter.sv @@
// ---------------------------------------------------------------------------
// planar_velocity_slew_limiter
// velocity command hold with timeout, planar speed cap, accel/decel slew
// limit and reversal stop; yaw handled as a scalar, Q16.16 values
//
//   channel  dir  handshake          payload
//   in_      in   tvalid / tready    tdata: cmd_x, cmd_y, cmd_yaw  tuser: op
//   out_     out  tvalid / tready    tdata: out_x, out_y, out_yaw  tuser: stale
//   cfg_     in   valid / ready      index, data
//
// a command word leaves the input ready; a tick keeps the input busy until
// its result is loaded: the sequencer waits on the square root and on each
// divide, and the speed cap and the step limit each run one root plus, when the
// vector is over its limit, two divides
// the next word is taken once the previous result sits in the output register
// reset (rst_n low, synchronous) loads the register defaults and clears state
// a stalled output holds its word; config is always ready
// ---------------------------------------------------------------------------
module planar_velocity_slew_limiter
  import pvsl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [3*VelW-1:0]   in_tdata,   // cmd_x, cmd_y, cmd_yaw
  input  logic                in_tuser,   // op
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [3*VelW-1:0]   out_tdata,  // out_x, out_y, out_yaw
  output logic                out_tuser,  // stale
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [VelW-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pvsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  pvsl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

@@ rtl/core/pvsl_sqrt.sv @@
// ---------------------------------------------------------------------------
// pvsl_sqrt
// integer square root, one root bit per cycle, floor result
// ---------------------------------------------------------------------------
module pvsl_sqrt
  import pvsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RadW-1:0]  rad,
  output logic             done,
  output logic [RootW-1:0] root
);

  localparam int unsigned Steps = RootW;
  localparam int unsigned CntW  = $clog2(Steps);
  localparam int unsigned RemW  = RootW + 3;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [RadW-1:0]  rad_r, rad_nxt;
  logic [RemW-1:0]  rem_r, rem_nxt;
  logic [RootW-1:0] root_r, root_nxt;
  logic [RemW-1:0]  rem_sh;
  logic [RemW-1:0]  trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r[RemW-3:0], rad_r[RadW-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RootW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RootW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(Steps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ rtl/core/pvsl_div.sv @@
// ---------------------------------------------------------------------------
// pvsl_div
// restoring divider, one quotient bit per cycle
// caller guarantees the quotient fits QuotW bits
// ---------------------------------------------------------------------------
module pvsl_div
  import pvsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DvdW-1:0]  dividend,
  input  logic [RootW-1:0] divisor,
  output logic             done,
  output logic [QuotW-1:0] quot
);

  localparam int unsigned CntW = $clog2(QuotW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [RootW-1:0] rem_r, rem_nxt;
  logic [QuotW-1:0] low_r, low_nxt;
  logic [RootW-1:0] dvs_r, dvs_nxt;
  logic [RootW:0]   rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, low_r[QuotW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, dividend[DvdW-1:QuotW]};
      low_nxt  = dividend[QuotW-1:0];
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // quotient bits shift in where dividend bits shift out
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = RootW'(rem_sh - {1'b0, dvs_r});
        low_nxt = {low_r[QuotW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[RootW-1:0];
        low_nxt = {low_r[QuotW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(QuotW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = low_r;

endmodule

@@ rtl/core/pvsl_dp.sv @@
// ---------------------------------------------------------------------------
// pvsl_dp
// limiter datapath: registers, held command, shared multiplier, root and
// divide units, yaw limiter
// ---------------------------------------------------------------------------
module pvsl_dp
  import pvsl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                cfg_valid,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [VelW-1:0]     cfg_data,
  input  logic [3*VelW-1:0]   in_tdata,
  output logic [3*VelW-1:0]   out_tdata,
  output logic                out_tuser
);

  logic signed [VelW-1:0] lin_lim_r, lin_acc_r, lin_dec_r;
  logic signed [VelW-1:0] yaw_lim_r, yaw_acc_r, yaw_dec_r;
  logic [VelW-1:0]        tmo_r;
  logic signed [VelW-1:0] held_x_r, held_y_r, held_yaw_r;
  logic [VelW-1:0]        cnt_r, cnt_nxt;
  logic signed [VelW-1:0] prev_x_r, prev_y_r, prev_yaw_r;
  logic signed [VelW-1:0] vx_r, vy_r, yaw_r;
  logic                   stale_r, stale_nxt;
  logic                   phase_r, accel_r;
  logic signed [ProdW-1:0] prod_r, acc_r;
  logic signed [VelW-1:0] out_x_r, out_y_r, out_yaw_r;
  logic                   out_stale_r;

  logic signed [OpW-1:0]  a_op, b_op, ma, mb, qs;
  logic [RootW-1:0]       a_mag, b_mag;
  logic signed [VelW-1:0] lim_sel;
  logic signed [ProdW-1:0] prod_w, sum_w;
  logic [RootW-1:0]       root;
  logic [QuotW-1:0]       quot;
  logic                   sqrt_done, div_done;

  // yaw limiter terms
  logic signed [OpW-1:0]  yv, ya, ystep, yv2, ya_mag, yaw_res;
  logic                   ya_pos, ya_neg, yp_pos, yp_neg, y_accel, y_apply;

  // ---- operand selection: phase 0 works on velocity, phase 1 on change
  always_comb begin
    if (phase_r) begin
      a_op = OpW'(vx_r) - OpW'(prev_x_r);
      b_op = OpW'(vy_r) - OpW'(prev_y_r);
    end else begin
      a_op = OpW'(vx_r);
      b_op = OpW'(vy_r);
    end
    a_mag   = a_op[OpW-1] ? RootW'(-a_op) : RootW'(a_op);
    b_mag   = b_op[OpW-1] ? RootW'(-b_op) : RootW'(b_op);
    lim_sel = phase_r ? (accel_r ? lin_acc_r : lin_dec_r) : lin_lim_r;
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SQ_A:  begin ma = a_op; mb = a_op; end
      MUL_SQ_B:  begin ma = b_op; mb = b_op; end
      MUL_DOT_A: begin ma = a_op; mb = OpW'(prev_x_r); end
      MUL_DOT_B: begin ma = b_op; mb = OpW'(prev_y_r); end
      MUL_LIM_A: begin ma = {1'b0, a_mag}; mb = OpW'(lim_sel); end
      MUL_LIM_B: begin ma = {1'b0, b_mag}; mb = OpW'(lim_sel); end
      default:   begin ma = a_op; mb = a_op; end
    endcase
  end

  assign prod_w = ma * mb;
  assign sum_w  = acc_r + prod_r;

  pvsl_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .rad   (sum_w[RadW-1:0]),
    .done  (sqrt_done),
    .root  (root)
  );

  pvsl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r[DvdW-1:0]),
    .divisor  (root),
    .done     (div_done),
    .quot     (quot)
  );

  // signed quotient for whichever component is written
  always_comb begin
    if (cmd.wr_b) begin
      qs = b_op[OpW-1] ? -OpW'(quot) : OpW'(quot);
    end else begin
      qs = a_op[OpW-1] ? -OpW'(quot) : OpW'(quot);
    end
  end

  // ---- tick count and staleness
  always_comb begin
    cnt_nxt   = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    stale_nxt = (tmo_r != '0) && (cnt_nxt > tmo_r);
  end

  // ---- yaw as a scalar
  always_comb begin
    yv = OpW'(yaw_r);
    if (!yaw_lim_r[VelW-1]) begin
      if (yv > OpW'(yaw_lim_r)) begin
        yv = OpW'(yaw_lim_r);
      end else if (yv < -OpW'(yaw_lim_r)) begin
        yv = -OpW'(yaw_lim_r);
      end
    end
    ya      = yv - OpW'(prev_yaw_r);
    ya_pos  = !ya[OpW-1] && (ya != '0);
    ya_neg  = ya[OpW-1];
    yp_pos  = !prev_yaw_r[VelW-1] && (prev_yaw_r != '0);
    yp_neg  = prev_yaw_r[VelW-1];
    y_accel = (!yp_pos && !yp_neg) || (ya_pos && yp_pos) || (ya_neg && yp_neg);
    ya_mag  = ya_neg ? -ya : ya;
    ystep   = OpW'(y_accel ? yaw_acc_r : yaw_dec_r);
    y_apply = (y_accel ? !ystep[OpW-1] : (!ystep[OpW-1] && ystep != '0))
              && (ya_mag > ystep);
    yv2     = yv;
    if (y_apply) begin
      yv2 = ya_neg ? OpW'(prev_yaw_r) - ystep : OpW'(prev_yaw_r) + ystep;
    end
    yaw_res = yv2;
    // deceleration must not carry through zero
    if (!y_accel) begin
      if (yp_pos ? (yv2[OpW-1] || yv2 == '0) : !yv2[OpW-1]) begin
        yaw_res = '0;
      end
    end
  end

  // ---- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_lim_r <= '1;
      lin_acc_r <= '1;
      lin_dec_r <= '0;
      yaw_lim_r <= VelW'(65536);
      yaw_acc_r <= '1;
      yaw_dec_r <= '0;
      tmo_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LIN_SPEED_LIMIT: lin_lim_r <= cfg_data;
        REG_LIN_ACCEL_STEP:  lin_acc_r <= cfg_data;
        REG_LIN_DECEL_STEP:  lin_dec_r <= cfg_data;
        REG_YAW_SPEED_LIMIT: yaw_lim_r <= cfg_data;
        REG_YAW_ACCEL_STEP:  yaw_acc_r <= cfg_data;
        REG_YAW_DECEL_STEP:  yaw_dec_r <= cfg_data;
        REG_TIMEOUT_TICKS:   tmo_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r   <= '0;
      held_y_r   <= '0;
      held_yaw_r <= '0;
      cnt_r      <= '0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      prev_yaw_r <= '0;
      phase_r    <= 1'b0;
      accel_r    <= 1'b0;
    end else begin
      if (cmd.load_cmd) begin
        held_x_r   <= in_tdata[VelW-1:0];
        held_y_r   <= in_tdata[2*VelW-1:VelW];
        held_yaw_r <= in_tdata[3*VelW-1:2*VelW];
        cnt_r      <= '0;
      end else if (cmd.load_tick) begin
        cnt_r <= cnt_nxt;
      end
      if (cmd.out_load) begin
        prev_x_r   <= vx_r;
        prev_y_r   <= vy_r;
        prev_yaw_r <= yaw_r;
      end
      if (cmd.set_phase) begin
        phase_r <= cmd.phase;
      end
      if (cmd.set_accel) begin
        accel_r <= !sum_w[ProdW-1];
      end
    end
  end

  // ---- working registers
  always_ff @(posedge clk) begin
    if (cmd.load_tick) begin
      stale_r <= stale_nxt;
      vx_r    <= stale_nxt ? '0 : held_x_r;
      vy_r    <= stale_nxt ? '0 : held_y_r;
      yaw_r   <= stale_nxt ? '0 : held_yaw_r;
    end else begin
      if (cmd.yaw_upd) begin
        yaw_r <= yaw_res[VelW-1:0];
      end
      if (cmd.zero_v) begin
        vx_r <= '0;
        vy_r <= '0;
      end else if (cmd.wr_a) begin
        vx_r <= phase_r ? VelW'(OpW'(prev_x_r) + qs) : qs[VelW-1:0];
      end else if (cmd.wr_b) begin
        vy_r <= phase_r ? VelW'(OpW'(prev_y_r) + qs) : qs[VelW-1:0];
      end
    end
    if (cmd.mul_en) begin
      acc_r  <= prod_r;
      prod_r <= prod_w;
    end
    if (cmd.out_load) begin
      out_x_r     <= vx_r;
      out_y_r     <= vy_r;
      out_yaw_r   <= yaw_r;
      out_stale_r <= stale_r;
    end
  end

  always_comb begin
    sts.spd_en    = !lin_lim_r[VelW-1];
    sts.over      = root > {2'b00, lim_sel[VelW-2:0]};
    sts.step_en   = accel_r ? !lin_acc_r[VelW-1]
                            : (!lin_dec_r[VelW-1] && lin_dec_r != '0);
    sts.accel     = accel_r;
    sts.neg       = sum_w[ProdW-1];
    sts.phase     = phase_r;
    sts.sqrt_done = sqrt_done;
    sts.div_done  = div_done;
  end

  assign out_tdata = {out_yaw_r, out_y_r, out_x_r};
  assign out_tuser = out_stale_r;

endmodule

@@ rtl/core/pvsl_ctrl.sv @@
// ---------------------------------------------------------------------------
// pvsl_ctrl
// sequencer for one tick: yaw, speed cap, accel/decel step, reversal check
// ---------------------------------------------------------------------------
`include "planar_velocity_slew_limiter_macros.svh"

module pvsl_ctrl
  import pvsl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_op,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;
  state_t after_scale;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    if (!sts.phase) begin
      after_scale = S_DOTA;
    end else begin
      after_scale = sts.accel ? S_OUT : S_REVA;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid && in_op) state_nxt = S_YAW;
      S_YAW:   state_nxt = sts.spd_en ? S_SQA : S_DOTA;
      S_SQA:   state_nxt = S_SQB;
      S_SQB:   state_nxt = S_SQRT;
      S_SQRT:  state_nxt = S_SQRTW;
      S_SQRTW: if (sts.sqrt_done) state_nxt = S_CMP;
      S_CMP:   state_nxt = sts.over ? S_LIMA : after_scale;
      S_LIMA:  state_nxt = S_DIVA;
      S_DIVA:  state_nxt = S_DIVAW;
      S_DIVAW: if (sts.div_done) state_nxt = S_LIMB;
      S_LIMB:  state_nxt = S_DIVB;
      S_DIVB:  state_nxt = S_DIVBW;
      S_DIVBW: if (sts.div_done) state_nxt = after_scale;
      S_DOTA:  state_nxt = S_DOTB;
      S_DOTB:  state_nxt = S_ACC;
      S_ACC:   state_nxt = S_STEP;
      S_STEP: begin
        if (sts.step_en) begin
          state_nxt = S_SQA;
        end else begin
          state_nxt = sts.accel ? S_OUT : S_REVA;
        end
      end
      S_REVA:  state_nxt = S_REVB;
      S_REVB:  state_nxt = S_REVC;
      S_REVC:  state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_SQ_A;
    unique case (state_r)
      S_IDLE: begin
        cmd.load_cmd  = in_tvalid && !in_op;
        cmd.load_tick = in_tvalid && in_op;
      end
      S_YAW: begin
        cmd.yaw_upd   = 1'b1;
        cmd.set_phase = 1'b1;
        cmd.phase     = !sts.spd_en;
      end
      S_SQA:   begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_SQ_A; end
      S_SQB:   begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_SQ_B; end
      S_SQRT:  cmd.sqrt_start = 1'b1;
      S_SQRTW: ;
      S_CMP: begin
        // leaving the scaling block flips the phase
        cmd.set_phase = !sts.over;
        cmd.phase     = !sts.phase;
      end
      S_LIMA:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_LIM_A; end
      S_DIVA:  cmd.div_start = 1'b1;
      S_DIVAW: cmd.wr_a = sts.div_done;
      S_LIMB:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_LIM_B; end
      S_DIVB:  cmd.div_start = 1'b1;
      S_DIVBW: begin
        cmd.wr_b      = sts.div_done;
        cmd.set_phase = sts.div_done;
        cmd.phase     = !sts.phase;
      end
      S_DOTA:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DOT_A; end
      S_DOTB:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DOT_B; end
      S_ACC:   cmd.set_accel = 1'b1;
      S_STEP: begin
        cmd.set_phase = !sts.step_en;
        cmd.phase     = 1'b0;
      end
      S_REVA:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DOT_A; end
      S_REVB:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DOT_B; end
      S_REVC:  cmd.zero_v = sts.neg;
      S_OUT:   cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else begin
      out_tvalid_nxt = out_tvalid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  `PVSL_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_tvalid_r || out_tready, "result overwritten")
  `PVSL_ASSERT_IMP(a_sqrt_wait, sts.sqrt_done, state_r == S_SQRTW, "root finished out of step")
  `PVSL_ASSERT_IMP(a_div_wait, sts.div_done, state_r == S_DIVAW || state_r == S_DIVBW, "quotient finished out of step")
  `PVSL_ASSERT_NXT(a_tick_busy, in_tvalid && in_tready && in_op, !in_tready, "tick not sequenced")

endmodule
